>>> rtl/lzwhde_pkg.sv
package lzwhde_pkg;

  localparam int HASH_SLOTS    = 5003;
  localparam int MAX_CODE_BITS = 12;
  localparam int HASH_SHIFT    = 5;

  localparam int CODE_W  = 12;
  localparam int WIDTH_W = 4;
  localparam int SYM_W   = 8;
  localparam int ALPHA_W = 4;
  localparam int NFC_W   = MAX_CODE_BITS + 1;
  localparam int SLOT_AW = $clog2(HASH_SLOTS);

  localparam logic [SLOT_AW:0]   SLOTS_X    = (SLOT_AW + 1)'(HASH_SLOTS);
  localparam logic [SLOT_AW-1:0] SLOT_LAST  = SLOT_AW'(HASH_SLOTS - 1);
  localparam logic [NFC_W-1:0]   CODE_LIMIT = NFC_W'(1) << MAX_CODE_BITS;

  localparam logic [ALPHA_W-1:0] ALPHA_MIN   = ALPHA_W'(2);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = ALPHA_W'(8);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(8);

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_ALPHA = CFG_AW'(0);

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [0:0] {
    MODE_DATA   = 1'b0,
    MODE_FINISH = 1'b1
  } mode_t;

  typedef struct packed {
    logic [0:0]       mode;
    logic [SYM_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] code_bits;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prefix;
    logic [SYM_W-1:0]  suffix;
  } slot_t;

  function automatic out_item_t mk_out(input logic [CODE_W-1:0] code,
                                       input logic [WIDTH_W-1:0] bits,
                                       input logic last);
    out_item_t o;
    o.code      = code;
    o.code_bits = bits;
    o.last      = last;
    return o;
  endfunction

  // ((prefix ^ sym) << 5) mod HASH_SLOTS. The operand is below HASH_SLOTS, so
  // each doubling needs at most one subtraction.
  function automatic logic [SLOT_AW-1:0] slot_hash(input logic [CODE_W-1:0] prefix,
                                                   input logic [SYM_W-1:0] sym);
    logic [SLOT_AW:0] r;
    r = (SLOT_AW + 1)'(prefix ^ CODE_W'(sym));
    for (int i = 0; i < HASH_SHIFT; i++) begin
      r = r << 1;
      if (r >= SLOTS_X) begin
        r = r - SLOTS_X;
      end
    end
    return r[SLOT_AW-1:0];
  endfunction

endpackage

>>> rtl/lzw_hashed_dictionary_encoder.sv
// GIF-style LZW encoder with a 5003-slot hashed dictionary held in one
// single-port-read synchronous memory. After reset the block clears every dictionary
// slot before in_ready rises; the same pass follows a finish
// item or a dictionary restart whenever a code was inserted since the last pass.
// The first data item of a stream and a finish item are taken in S_IDLE alone.
// Any other data item goes on to S_PROBE and then S_CHECK, which repeats for each
// probe into the hash memory (one memory read per cycle).
// Results go through a 4-entry queue, so a new item is taken while up to two
// earlier results are still waiting on the output.
module lzw_hashed_dictionary_encoder import lzwhde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,

  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PROBE = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  // Configuration register
  logic [ALPHA_W-1:0] alpha_r;
  logic [CFG_AW-1:0]  cfg_word;
  logic               cfg_hit;

  assign cfg_word   = cfg_paddr >> 2;
  assign cfg_hit    = (cfg_word == REG_ALPHA);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? {(CFG_DW - ALPHA_W)'(0), alpha_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      alpha_r <= cfg_pwdata[ALPHA_W-1:0];
    end
  end

  // Codes derived from the alphabet size
  logic [ALPHA_W-1:0] alpha_eff;
  logic [CODE_W-1:0]  clear_code;
  logic [CODE_W-1:0]  fin_code;
  logic [WIDTH_W-1:0] width_start;
  logic [NFC_W-1:0]   nfc_start;
  logic [SYM_W-1:0]   sym_mask;
  logic [SYM_W-1:0]   in_sym;

  always_comb begin
    alpha_eff = alpha_r;
    if (alpha_r < ALPHA_MIN) begin
      alpha_eff = ALPHA_MIN;
    end else if (alpha_r > ALPHA_MAX) begin
      alpha_eff = ALPHA_MAX;
    end
  end

  assign clear_code  = CODE_W'(1) << alpha_eff;
  assign fin_code    = clear_code + CODE_W'(1);
  assign width_start = WIDTH_W'(alpha_eff) + WIDTH_W'(1);
  assign nfc_start   = NFC_W'(clear_code) + NFC_W'(2);
  assign sym_mask    = SYM_W'(clear_code - CODE_W'(1));
  assign in_sym      = in_item.data_byte & sym_mask;

  // Encoder state
  state_t             state_r, state_nxt;
  logic [CODE_W-1:0]  pending_r, pending_nxt;
  logic [NFC_W-1:0]   nfc_r, nfc_nxt;
  logic [WIDTH_W-1:0] cw_r, cw_nxt;
  logic               fresh_r, fresh_nxt;
  logic               dirty_r, dirty_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [SLOT_AW-1:0] h_r, h_nxt;
  logic [SLOT_AW-1:0] step_r, step_nxt;
  logic [SLOT_AW-1:0] probes_r, probes_nxt;
  logic [SLOT_AW-1:0] clr_r, clr_nxt;

  // Dictionary memory
  slot_t              slot_mem [HASH_SLOTS];
  slot_t              rd_data_r;
  logic [SLOT_AW-1:0] mem_raddr;
  logic               mem_we;
  logic [SLOT_AW-1:0] mem_waddr;
  slot_t              mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_mem[mem_raddr];
  end

  // Next probe position: both sums stay below twice the slot count.
  logic [SLOT_AW:0]   h_sum, step_sum;
  logic [SLOT_AW-1:0] h_adv, step_adv;

  always_comb begin
    h_sum    = (SLOT_AW + 1)'(h_r) + (SLOT_AW + 1)'(step_r);
    step_sum = (SLOT_AW + 1)'(step_r) + (SLOT_AW + 1)'(2);
    if (h_sum >= SLOTS_X) begin
      h_sum = h_sum - SLOTS_X;
    end
    if (step_sum >= SLOTS_X) begin
      step_sum = step_sum - SLOTS_X;
    end
    h_adv    = h_sum[SLOT_AW-1:0];
    step_adv = step_sum[SLOT_AW-1:0];
  end

  // Result queue
  out_item_t        oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_head_r, oq_tail_r;
  logic [OQ_CW-1:0] oq_cnt_r;
  logic [1:0]       push_cnt;
  out_item_t        push0, push1;
  logic             pop;
  logic             accept;

  assign out_valid = (oq_cnt_r != '0);
  assign out_item  = oq_mem[oq_head_r];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (state_r == S_IDLE) && (oq_cnt_r <= OQ_CW'(OQ_DEPTH - 2));
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_head_r <= '0;
      oq_tail_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      if (pop) begin
        oq_head_r <= oq_head_r + OQ_AW'(1);
      end
      oq_tail_r <= oq_tail_r + OQ_AW'(push_cnt);
      oq_cnt_r  <= oq_cnt_r + OQ_CW'(push_cnt) - OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      oq_mem[oq_tail_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      oq_mem[oq_tail_r + OQ_AW'(1)] <= push1;
    end
  end

  // Control
  logic [WIDTH_W-1:0] cw_use;
  logic [NFC_W-1:0]   width_pow;
  slot_t              ent;

  assign cw_use    = fresh_r ? width_start : cw_r;
  assign width_pow = NFC_W'(1) << cw_r;
  assign ent       = rd_data_r;

  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    nfc_nxt     = nfc_r;
    cw_nxt      = cw_r;
    fresh_nxt   = fresh_r;
    dirty_nxt   = dirty_r;
    sym_nxt     = sym_r;
    h_nxt       = h_r;
    step_nxt    = step_r;
    probes_nxt  = probes_r;
    clr_nxt     = clr_r;
    push_cnt    = 2'd0;
    push0       = mk_out(pending_r, cw_r, 1'b1);
    push1       = mk_out(clear_code, cw_r, 1'b1);
    mem_raddr   = h_r;
    mem_we      = 1'b0;
    mem_waddr   = h_r;
    mem_wdata   = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + SLOT_AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          sym_nxt = in_sym;
          if (in_item.mode == MODE_FINISH) begin
            push_cnt    = 2'd2;
            push0       = mk_out(fresh_r ? clear_code : pending_r, cw_use, 1'b0);
            push1       = mk_out(fin_code, cw_use, 1'b1);
            cw_nxt      = width_start;
            nfc_nxt     = nfc_start;
            pending_nxt = '0;
            fresh_nxt   = 1'b1;
            // Skip the clearing pass when nothing was inserted since the last one.
            if (dirty_r) begin
              state_nxt = S_CLEAR;
              clr_nxt   = '0;
              dirty_nxt = 1'b0;
            end
          end else if (fresh_r) begin
            push_cnt    = 2'd1;
            push0       = mk_out(clear_code, width_start, 1'b1);
            cw_nxt      = width_start;
            nfc_nxt     = nfc_start;
            pending_nxt = CODE_W'(in_sym);
            fresh_nxt   = 1'b0;
          end else begin
            h_nxt      = slot_hash(pending_r, in_sym);
            step_nxt   = SLOT_AW'(1);
            probes_nxt = '0;
            state_nxt  = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (ent.code == '0) begin
          // Empty slot: emit the prefix and, while codes remain, add the new string.
          push_cnt    = 2'd1;
          push0       = mk_out(pending_r, cw_r, 1'b1);
          pending_nxt = CODE_W'(sym_r);
          state_nxt   = S_IDLE;
          if (nfc_r < CODE_LIMIT) begin
            mem_we           = 1'b1;
            mem_waddr        = h_r;
            mem_wdata.code   = nfc_r[CODE_W-1:0];
            mem_wdata.prefix = pending_r;
            mem_wdata.suffix = sym_r;
            nfc_nxt          = nfc_r + NFC_W'(1);
            dirty_nxt        = 1'b1;
          end
          if (nfc_r == width_pow) begin
            if (cw_r < WIDTH_W'(MAX_CODE_BITS)) begin
              cw_nxt = cw_r + WIDTH_W'(1);
            end else begin
              // Width cannot grow: send the prefix and a clear code, then restart the dictionary.
              push_cnt  = 2'd2;
              push0     = mk_out(pending_r, cw_r, 1'b0);
              push1     = mk_out(clear_code, cw_r, 1'b1);
              cw_nxt    = width_start;
              nfc_nxt   = nfc_start;
              state_nxt = S_CLEAR;
              clr_nxt   = '0;
              dirty_nxt = 1'b0;
            end
          end
        end else if (ent.prefix == pending_r && ent.suffix == sym_r) begin
          pending_nxt = ent.code;
          state_nxt   = S_IDLE;
        end else if (probes_r == SLOT_LAST) begin
          push_cnt    = 2'd1;
          push0       = mk_out(pending_r, cw_r, 1'b1);
          pending_nxt = CODE_W'(sym_r);
          state_nxt   = S_IDLE;
        end else begin
          // Issue the next probe read now so one probe completes per cycle.
          mem_raddr  = h_adv;
          h_nxt      = h_adv;
          step_nxt   = step_adv;
          probes_nxt = probes_r + SLOT_AW'(1);
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      pending_r <= '0;
      nfc_r     <= NFC_W'(CODE_W'(1) << ALPHA_RESET) + NFC_W'(2);
      cw_r      <= WIDTH_W'(ALPHA_RESET) + WIDTH_W'(1);
      fresh_r   <= 1'b1;
      dirty_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      pending_r <= pending_nxt;
      nfc_r     <= nfc_nxt;
      cw_r      <= cw_nxt;
      fresh_r   <= fresh_nxt;
      dirty_r   <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r    <= sym_nxt;
    h_r      <= h_nxt;
    step_r   <= step_nxt;
    probes_r <= probes_nxt;
  end

endmodule

>>> verif/lzw_hashed_dictionary_encoder_tb.sv
module lzw_hashed_dictionary_encoder_tb;
  import lzwhde_pkg::*;

  // A hit makes no code, and a finish or a restart may start a clearing pass
  // over every hash slot, so this is how long the block may stay busy.
  localparam int DRAIN_CYCLES = HASH_SLOTS + 64;
  localparam int CYCLE_LIMIT  = 8000000;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_item_t          in_item     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_item_t         out_item;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Encoder state as the testbench tracks it.
  logic [CODE_W-1:0]  dict_code   [HASH_SLOTS];
  logic [CODE_W-1:0]  dict_prefix [HASH_SLOTS];
  logic [SYM_W-1:0]   dict_suffix [HASH_SLOTS];
  logic [CODE_W-1:0]  cur_prefix;
  logic [NFC_W-1:0]   free_code;
  logic [WIDTH_W-1:0] code_width;
  logic               at_start;
  logic [ALPHA_W-1:0] alpha_reg;
  out_item_t          lzw_codes_q[$];

  int        src_idle_pct = 0;
  int        dst_idle_pct = 0;
  int        hold_cycles  = 0;
  int        mismatch_cnt = 0;
  int        cycle_cnt    = 0;
  out_item_t want;

  lzw_hashed_dictionary_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned eff_alpha();
    int unsigned a;
    a = alpha_reg;
    if (a < 2) a = 2;
    if (a > 8) a = 8;
    return a;
  endfunction

  task automatic restart_dict();
    int unsigned a;
    a = eff_alpha();
    for (int i = 0; i < HASH_SLOTS; i++) dict_code[i] = '0;
    code_width = WIDTH_W'(a + 1);
    free_code  = NFC_W'((1 << a) + 2);
  endtask

  task automatic lzw_encode_step(input in_item_t it);
    int unsigned a, clr, sym, h, stp, taken;
    logic [WIDTH_W-1:0] w0;
    a   = eff_alpha();
    clr = 1 << a;
    sym = it.data_byte & (clr - 1);
    if (at_start) begin
      code_width = WIDTH_W'(a + 1);
      free_code  = NFC_W'(clr + 2);
    end
    if (it.mode == MODE_FINISH) begin
      lzw_codes_q.push_back('{code: at_start ? CODE_W'(clr) : cur_prefix,
                              code_bits: code_width, last: 1'b0});
      lzw_codes_q.push_back('{code: CODE_W'(clr + 1), code_bits: code_width, last: 1'b1});
      restart_dict();
      cur_prefix = '0;
      at_start   = 1'b1;
      return;
    end
    if (at_start) begin
      at_start   = 1'b0;
      cur_prefix = CODE_W'(sym);
      lzw_codes_q.push_back('{code: CODE_W'(clr), code_bits: code_width, last: 1'b1});
      return;
    end
    h   = ((cur_prefix ^ sym) << HASH_SHIFT) % HASH_SLOTS;
    stp = 1;
    for (int n = 0; n < HASH_SLOTS; n++) begin
      if (dict_code[h] == '0) begin
        taken = free_code;
        w0    = code_width;
        if (free_code < (1 << MAX_CODE_BITS)) begin
          dict_prefix[h] = cur_prefix;
          dict_suffix[h] = SYM_W'(sym);
          dict_code[h]   = free_code[CODE_W-1:0];
          free_code++;
        end
        if (taken == (1 << code_width) && code_width >= MAX_CODE_BITS) begin
          // No wider code is possible: flush, send a clear and start over.
          lzw_codes_q.push_back('{code: cur_prefix, code_bits: w0, last: 1'b0});
          lzw_codes_q.push_back('{code: CODE_W'(clr), code_bits: w0, last: 1'b1});
          restart_dict();
        end else begin
          if (taken == (1 << code_width)) code_width++;
          lzw_codes_q.push_back('{code: cur_prefix, code_bits: w0, last: 1'b1});
        end
        cur_prefix = CODE_W'(sym);
        return;
      end
      if (dict_prefix[h] == cur_prefix && dict_suffix[h] == SYM_W'(sym)) begin
        cur_prefix = dict_code[h];
        return;
      end
      h   = (h + stp) % HASH_SLOTS;
      stp = (stp + 2) % HASH_SLOTS;
    end
    // Every slot probed without a hit or a free slot.
    lzw_codes_q.push_back('{code: cur_prefix, code_bits: code_width, last: 1'b1});
    cur_prefix = CODE_W'(sym);
  endtask

  task automatic send_item(input mode_t m, input logic [SYM_W-1:0] b);
    in_item_t it;
    it = '{mode: m, data_byte: b};
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lzw_encode_step(it);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lzw_codes_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_alphabet_readback();
    logic [ALPHA_W-1:0] got;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= REG_ALPHA;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    got = cfg_prdata[ALPHA_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== alpha_reg) begin
      mismatch_cnt++;
      $display("%0t: alphabet_bits read back: expected %0d, actual %0d",
               $time, alpha_reg, got);
    end
  endtask

  task automatic set_alphabet(input logic [ALPHA_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ALPHA;
    cfg_pwdata  <= CFG_DW'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    alpha_reg = val;
    check_alphabet_readback();
  endtask

  // Three flavors: random bytes, a few symbols in any order, or a short
  // pattern repeated with some noise so that long strings build up.
  task automatic send_random_stream(input int len, input bit close);
    logic [SYM_W-1:0] pat [8];
    logic [SYM_W-1:0] b;
    int style, plen, pos;
    style = $urandom_range(2);
    plen  = (style == 1) ? $urandom_range(1, 3) : $urandom_range(1, 8);
    pos   = 0;
    for (int i = 0; i < 8; i++) pat[i] = SYM_W'($urandom_range(255));
    for (int i = 0; i < len; i++) begin
      case (style)
        0: b = SYM_W'($urandom_range(255));
        1: b = pat[$urandom_range(plen - 1)];
        default: begin
          b   = ($urandom_range(9) == 0) ? SYM_W'($urandom_range(255)) : pat[pos];
          pos = (pos + 1) % plen;
        end
      endcase
      send_item(MODE_DATA, b);
    end
    if (close) send_item(MODE_FINISH, SYM_W'($urandom_range(255)));
  endtask

  task automatic test_reset_value();
    check_alphabet_readback();
  endtask

  task automatic test_finish_only();
    send_item(MODE_FINISH, 8'h00);
    send_item(MODE_FINISH, 8'hFF);
  endtask

  task automatic test_symbol_extremes();
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'h80);
    send_item(MODE_DATA, 8'h7F);
    send_item(MODE_FINISH, 8'h00);
  endtask

  task automatic test_narrow_alphabet();
    wait_idle();
    set_alphabet(4'd2);
    // Bytes wider than the alphabet are cut down to their low bits.
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hFD);
    send_item(MODE_DATA, 8'h03);
    send_item(MODE_DATA, 8'h03);
    send_item(MODE_DATA, 8'h03);
    // Changing the register mid-stream moves clear and finish codes at once.
    wait_idle();
    set_alphabet(4'd5);
    send_item(MODE_DATA, 8'h1F);
    send_item(MODE_DATA, 8'hE0);
    send_item(MODE_FINISH, 8'h00);
    wait_idle();
    set_alphabet(4'd0);
    send_item(MODE_FINISH, 8'h00);
    wait_idle();
    set_alphabet(4'd1);
    send_item(MODE_DATA, 8'h02);
    send_item(MODE_FINISH, 8'h00);
    wait_idle();
    set_alphabet(4'd15);
    send_item(MODE_DATA, 8'hAB);
    send_item(MODE_FINISH, 8'h00);
    wait_idle();
    set_alphabet(4'd9);
    send_item(MODE_FINISH, 8'h00);
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_alphabet(4'd4);
    src_idle_pct = 0;
    dst_idle_pct = 20;
    send_item(MODE_DATA, SYM_W'($urandom_range(255)));
    // The receiver stops long enough for the result queue to fill up.
    hold_cycles = 400;
    repeat (60) send_item(MODE_DATA, SYM_W'($urandom_range(255)));
    wait_results();
    repeat (20) send_item(MODE_DATA, SYM_W'($urandom_range(255)));
    send_item(MODE_FINISH, 8'h00);
    dst_idle_pct = 0;
  endtask

  task automatic test_dictionary_full();
    wait_idle();
    set_alphabet(4'd5);
    // Random five-bit symbols miss often enough to widen the code a few times.
    repeat (200) send_item(MODE_DATA, SYM_W'($urandom_range(255)));
    send_item(MODE_FINISH, 8'h00);
  endtask

  task automatic test_random_streams();
    int sent, len;
    bit close;
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          src_idle_pct = 30;
          dst_idle_pct = 49;
        end
        1: begin
          src_idle_pct = 49;
          dst_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 3; ph++) begin
        wait_idle();
        set_alphabet(ALPHA_W'($urandom_range(15)));
        sent = 0;
        while (sent < 50) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 30);
          // The last stream of a phase may stay open across the register write.
          close = (sent + len + 1 < 50) || ($urandom_range(1) == 1);
          send_random_stream(len, close);
          sent += len + 1;
        end
      end
    end
    src_idle_pct = 0;
    dst_idle_pct = 0;
  endtask

  initial begin
    alpha_reg = ALPHA_RESET;
    restart_dict();
    cur_prefix = '0;
    at_start   = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_value();
    test_finish_only();
    test_symbol_extremes();
    test_narrow_alphabet();
    test_backpressure();
    test_dictionary_full();
    test_random_streams();

    wait_idle();
    if (mismatch_cnt == 0 && lzw_codes_q.size() == 0) begin
      $display("[lzw_hashed_dictionary_encoder] OK");
    end else begin
      $display("[lzw_hashed_dictionary_encoder] ERROR");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[lzw_hashed_dictionary_encoder] ERROR");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (lzw_codes_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: code with nothing expected: code %0d bits %0d last %0b",
                 $time, out_item.code, out_item.code_bits, out_item.last);
      end else begin
        want = lzw_codes_q.pop_front();
        if (out_item.code !== want.code || out_item.code_bits !== want.code_bits ||
            out_item.last !== want.last) begin
          mismatch_cnt++;
          $display("%0t: expected code %0d bits %0d last %0b, actual code %0d bits %0d last %0b",
                   $time, want.code, want.code_bits, want.last,
                   out_item.code, out_item.code_bits, out_item.last);
        end
      end
    end
  end

endmodule

>>> filelist.f
rtl/lzwhde_pkg.sv
rtl/lzw_hashed_dictionary_encoder.sv
verif/lzw_hashed_dictionary_encoder_tb.sv
